/* rtl/core/sfg_pkg.sv */
// ---------------------------------------------------------------------------
// sfg_pkg
// Shared types, constants and the cosine table builder for the sinusoidal
// fringe generator.
// ---------------------------------------------------------------------------
package sfg_pkg;

   localparam int PHASE_FRAC_BITS = 24;
   localparam int COS_ADDR_BITS   = 10;
   localparam int MAX_DIMENSION   = 4096;
   localparam int MAX_SHIFTS      = 64;

   localparam int DIM_BITS        = $clog2(MAX_DIMENSION);
   localparam int CFG_DIM_BITS    = DIM_BITS + 1;
   localparam int FRAME_BITS      = $clog2(MAX_SHIFTS);
   localparam int SHIFT_CNT_BITS  = FRAME_BITS + 1;
   localparam int GRAY_BITS       = 8;
   localparam int COS_BITS        = 16;
   localparam int COS_TABLE_SIZE  = 1 << COS_ADDR_BITS;

   localparam int CSR_INDEX_BITS  = 4;
   localparam int CSR_DATA_BITS   = PHASE_FRAC_BITS;

   // table address is the phase rounded to the top address bits
   localparam int ADDR_SHIFT = PHASE_FRAC_BITS - COS_ADDR_BITS;
   localparam logic [PHASE_FRAC_BITS-1:0] ADDR_ROUND =
      PHASE_FRAC_BITS'(64'd1 << (ADDR_SHIFT - 1));

   // frame shift divider: dividend is frame << P plus half the divisor
   localparam int DIV_W        = FRAME_BITS + PHASE_FRAC_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(DIV_W);

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH      = 4'd0,
      CSR_IMAGE_HEIGHT     = 4'd1,
      CSR_PIXEL_PHASE_STEP = 4'd2,
      CSR_SHIFT_COUNT      = 4'd3,
      CSR_GRAY_FLOOR       = 4'd4,
      CSR_GRAY_CEILING     = 4'd5,
      CSR_START_PHASE      = 4'd6,
      CSR_FRINGE_DIRECTION = 4'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOOK,
      ST_MIX,
      ST_DIV
   } sfg_state_type;

   typedef struct packed {
      logic [CFG_DIM_BITS-1:0]    image_width;
      logic [CFG_DIM_BITS-1:0]    image_height;
      logic [PHASE_FRAC_BITS-1:0] pixel_phase_step;
      logic [SHIFT_CNT_BITS-1:0]  shift_count;
      logic [GRAY_BITS-1:0]       gray_floor;
      logic [GRAY_BITS-1:0]       gray_ceiling;
      logic [PHASE_FRAC_BITS-1:0] start_phase;
      logic                       fringe_direction;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic look;
      logic load_out;
      logic div_start;
      logic div_step;
      logic div_last;
   } cmd_type;

   typedef struct packed {
      logic div_pend;
      logic out_free;
   } status_type;

   typedef logic signed [COS_BITS-1:0] cos_table_type [COS_TABLE_SIZE];

   // series term divisors, a*(a+1), cosine uses odd a and sine even a
   function automatic logic [63:0] series_div(input logic [63:0] value,
                                              input logic odd, input int n);
      logic [63:0] res;
      res = value;
      if (odd) begin
         case (n)
            1: res = value / 64'd6;
            2: res = value / 64'd20;
            3: res = value / 64'd42;
            4: res = value / 64'd72;
            5: res = value / 64'd110;
            6: res = value / 64'd156;
            7: res = value / 64'd210;
            8: res = value / 64'd272;
            default: res = value / 64'd342;
         endcase
      end else begin
         case (n)
            1: res = value / 64'd2;
            2: res = value / 64'd12;
            3: res = value / 64'd30;
            4: res = value / 64'd56;
            5: res = value / 64'd90;
            6: res = value / 64'd132;
            7: res = value / 64'd182;
            8: res = value / 64'd240;
            default: res = value / 64'd306;
         endcase
      end
      return res;
   endfunction

   // cos or sin of theta in Q30, theta in the first quadrant
   function automatic logic [63:0] series_q30(input logic [63:0] theta, input logic odd);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x2   = (theta * theta) >> 30;
      term = odd ? theta : ONE_Q30;
      sum  = signed'(term);
      for (int n = 1; n <= 9; n++) begin
         term = series_div((term * x2) >> 30, odd, n);
         if (n[0]) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      return unsigned'(sum);
   endfunction

   function automatic logic signed [COS_BITS-1:0] to_q15(input logic [63:0] v);
      logic [63:0] r;
      r = (v + (64'd1 << 14)) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return COS_BITS'(r);
   endfunction

   function automatic cos_table_type build_cos_table();
      cos_table_type            tab;
      logic [1:0]               quad;
      logic [63:0]              rem;
      logic [63:0]              theta;
      logic signed [COS_BITS-1:0] c_val;
      logic signed [COS_BITS-1:0] s_val;
      for (int i = 0; i < COS_TABLE_SIZE; i++) begin
         quad  = 2'(i >> (COS_ADDR_BITS - 2));
         rem   = 64'(i) & ((64'd1 << (COS_ADDR_BITS - 2)) - 64'd1);
         theta = (TWO_PI_Q30 * rem + (64'd1 << (COS_ADDR_BITS - 1))) >> COS_ADDR_BITS;
         c_val = to_q15(series_q30(theta, 1'b0));
         s_val = to_q15(series_q30(theta, 1'b1));
         case (quad)
            2'd0:    tab[i] = c_val;
            2'd1:    tab[i] = -s_val;
            2'd2:    tab[i] = -c_val;
            default: tab[i] = s_val;
         endcase
      end
      return tab;
   endfunction

endpackage

/* rtl/core/sfg_csr.sv */
// ---------------------------------------------------------------------------
// sfg_csr
// Configuration registers, settings check and position home pulse.
// ---------------------------------------------------------------------------
module sfg_csr
   import sfg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output cfg_type                   cfg,
   output logic                      cfg_bad,
   output logic                      home
);

   cfg_type cfg_ff, cfg_in;
   logic    home_in;

   always_comb begin
      cfg_in  = cfg_ff;
      home_in = 1'b0;
      if (csr_write_enable) begin
         home_in = 1'b1;
         case (csr_index)
            CSR_IMAGE_WIDTH:      cfg_in.image_width      = csr_write_data[CFG_DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT:     cfg_in.image_height     = csr_write_data[CFG_DIM_BITS-1:0];
            CSR_PIXEL_PHASE_STEP: cfg_in.pixel_phase_step = csr_write_data[PHASE_FRAC_BITS-1:0];
            CSR_SHIFT_COUNT:      cfg_in.shift_count      = csr_write_data[SHIFT_CNT_BITS-1:0];
            CSR_GRAY_FLOOR:       cfg_in.gray_floor       = csr_write_data[GRAY_BITS-1:0];
            CSR_GRAY_CEILING:     cfg_in.gray_ceiling     = csr_write_data[GRAY_BITS-1:0];
            CSR_START_PHASE:      cfg_in.start_phase      = csr_write_data[PHASE_FRAC_BITS-1:0];
            CSR_FRINGE_DIRECTION: cfg_in.fringe_direction = csr_write_data[0];
            default:              home_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= CFG_DIM_BITS'(640);
         cfg_ff.image_height     <= CFG_DIM_BITS'(480);
         cfg_ff.pixel_phase_step <= PHASE_FRAC_BITS'(262144);
         cfg_ff.shift_count      <= SHIFT_CNT_BITS'(4);
         cfg_ff.gray_floor       <= '0;
         cfg_ff.gray_ceiling     <= '1;
         cfg_ff.start_phase      <= '0;
         cfg_ff.fringe_direction <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg  = cfg_ff;
   assign home = home_in;

   assign cfg_bad = (cfg_ff.image_width == '0)
                 || (cfg_ff.image_width > CFG_DIM_BITS'(MAX_DIMENSION))
                 || (cfg_ff.image_height == '0)
                 || (cfg_ff.image_height > CFG_DIM_BITS'(MAX_DIMENSION))
                 || (cfg_ff.shift_count < SHIFT_CNT_BITS'(3))
                 || (cfg_ff.shift_count > SHIFT_CNT_BITS'(MAX_SHIFTS))
                 || (cfg_ff.gray_floor >= cfg_ff.gray_ceiling);

endmodule

/* rtl/core/sfg_ctrl.sv */
// ---------------------------------------------------------------------------
// sfg_ctrl
// Sequencer: accept, phase multiply, table read, mix, then the frame shift
// division when a frame has just advanced.
// ---------------------------------------------------------------------------
module sfg_ctrl
   import sfg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   sfg_state_type           state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // hold here while the previous request still sits in the output
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.div_pend) begin
                  cmd.div_start = 1'b1;
                  div_cnt_in    = '0;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_W - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/sfg_dp.sv */
// ---------------------------------------------------------------------------
// sfg_dp
// Datapath: raster position, phase multiply, cosine table, gray mix,
// output register and the restoring divider for the frame shift.
// ---------------------------------------------------------------------------
module sfg_dp
   import sfg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  cfg_type              cfg,
   input  logic                 cfg_bad,
   input  logic                 home,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [GRAY_BITS-1:0] rsp_gray,
   output logic [DIM_BITS-1:0]  rsp_column,
   output logic [DIM_BITS-1:0]  rsp_row,
   output logic [FRAME_BITS-1:0] rsp_frame_index,
   output logic                 rsp_end_of_frame,
   output logic                 rsp_end_of_set,
   output logic                 rsp_config_error
);

   localparam cos_table_type COS_TABLE = build_cos_table();

   // position state
   logic [DIM_BITS-1:0]        col_ff, col_in;
   logic [DIM_BITS-1:0]        row_ff, row_in;
   logic [FRAME_BITS-1:0]      frame_ff, frame_in;
   logic [PHASE_FRAC_BITS-1:0] shift_ff, shift_in;
   logic                       div_pend_ff, div_pend_in;

   // per-request working registers
   logic [DIM_BITS-1:0]        snap_col_ff, snap_row_ff, coord_ff;
   logic [FRAME_BITS-1:0]      snap_frame_ff;
   logic                       snap_eof_ff, snap_eos_ff, snap_err_ff;
   logic [PHASE_FRAC_BITS-1:0] base_ff, coord_phase_ff;
   logic signed [COS_BITS-1:0] cos_ff;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [GRAY_BITS-1:0]       rsp_gray_ff;
   logic [DIM_BITS-1:0]        rsp_col_ff, rsp_row_ff;
   logic [FRAME_BITS-1:0]      rsp_frame_ff;
   logic                       rsp_eof_ff, rsp_eos_ff, rsp_err_ff;

   // divider
   logic [DIV_W-1:0]           div_work_ff, div_work_in;
   logic [SHIFT_CNT_BITS-1:0]  div_rem_ff, div_rem_in;
   logic [SHIFT_CNT_BITS:0]    div_rem_sh;
   logic                       div_ge;

   // accept-time position logic
   logic [DIM_BITS-1:0]        col_base, row_base;
   logic [FRAME_BITS-1:0]      frame_base;
   logic [PHASE_FRAC_BITS-1:0] shift_base;
   logic [CFG_DIM_BITS-1:0]    col_next_cnt, row_next_cnt;
   logic [SHIFT_CNT_BITS-1:0]  frame_next_cnt;
   logic                       col_last, row_last, frame_last;
   logic                       eof_val, eos_val;

   // phase and mix
   logic [PHASE_FRAC_BITS+DIM_BITS-1:0] mul_full;
   logic [PHASE_FRAC_BITS-1:0] phase_sum;
   logic [COS_ADDR_BITS-1:0]   cos_addr;
   logic [GRAY_BITS:0]         gray_sum;
   logic signed [GRAY_BITS+1:0] gray_span;
   logic signed [GRAY_BITS+COS_BITS+1:0] span_prod;
   logic signed [GRAY_BITS+COS_BITS+2:0] mix_val, mix_round;
   logic [GRAY_BITS+2:0]       gray_wide;
   logic [GRAY_BITS-1:0]       gray_val;

   assign col_base   = req_restart ? '0 : col_ff;
   assign row_base   = req_restart ? '0 : row_ff;
   assign frame_base = req_restart ? '0 : frame_ff;
   assign shift_base = req_restart ? '0 : shift_ff;

   assign col_next_cnt   = {1'b0, col_base} + CFG_DIM_BITS'(1);
   assign row_next_cnt   = {1'b0, row_base} + CFG_DIM_BITS'(1);
   assign frame_next_cnt = {1'b0, frame_base} + SHIFT_CNT_BITS'(1);
   assign col_last   = col_next_cnt >= cfg.image_width;
   assign row_last   = row_next_cnt >= cfg.image_height;
   assign frame_last = frame_next_cnt >= cfg.shift_count;
   assign eof_val    = !cfg_bad && col_last && row_last;
   assign eos_val    = eof_val && frame_last;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      frame_in    = frame_ff;
      shift_in    = shift_ff;
      div_pend_in = div_pend_ff;
      if (home) begin
         col_in      = '0;
         row_in      = '0;
         frame_in    = '0;
         shift_in    = '0;
         div_pend_in = 1'b0;
      end else if (cmd.accept) begin
         col_in      = col_base;
         row_in      = row_base;
         frame_in    = frame_base;
         shift_in    = shift_base;
         div_pend_in = 1'b0;
         if (!cfg_bad) begin
            if (col_last) begin
               col_in = '0;
               if (row_last) begin
                  row_in = '0;
                  if (frame_last) begin
                     frame_in = '0;
                     shift_in = '0;
                  end else begin
                     // new frame shift comes from the divider after this request
                     frame_in    = frame_next_cnt[FRAME_BITS-1:0];
                     div_pend_in = 1'b1;
                  end
               end else begin
                  row_in = row_next_cnt[DIM_BITS-1:0];
               end
            end else begin
               col_in = col_next_cnt[DIM_BITS-1:0];
            end
         end
      end else if (cmd.div_step && cmd.div_last) begin
         shift_in    = div_work_in[PHASE_FRAC_BITS-1:0];
         div_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         frame_ff    <= '0;
         shift_ff    <= '0;
         div_pend_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         frame_ff    <= frame_in;
         shift_ff    <= shift_in;
         div_pend_ff <= div_pend_in;
      end
   end

   // request snapshot
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         snap_col_ff   <= col_base;
         snap_row_ff   <= row_base;
         snap_frame_ff <= frame_base;
         snap_eof_ff   <= eof_val;
         snap_eos_ff   <= eos_val;
         snap_err_ff   <= cfg_bad;
         coord_ff      <= cfg.fringe_direction ? row_base : col_base;
         base_ff       <= shift_base + cfg.start_phase + ADDR_ROUND;
      end
   end

   // phase of the coordinate, wraps modulo one turn
   assign mul_full = cfg.pixel_phase_step * coord_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         coord_phase_ff <= mul_full[PHASE_FRAC_BITS-1:0];
      end
   end

   assign phase_sum = coord_phase_ff + base_ff;
   assign cos_addr  = phase_sum[PHASE_FRAC_BITS-1 -: COS_ADDR_BITS];

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         cos_ff <= COS_TABLE[cos_addr];
      end
   end

   // offset*2^16 + span*cos with offset and span at half scale
   assign gray_sum  = {1'b0, cfg.gray_floor} + {1'b0, cfg.gray_ceiling};
   assign gray_span = signed'({2'b00, cfg.gray_ceiling}) - signed'({2'b00, cfg.gray_floor});
   assign span_prod = gray_span * cos_ff;
   assign mix_val   = signed'({3'b000, gray_sum, 15'd0})
                    + (GRAY_BITS+COS_BITS+3)'(span_prod);
   assign mix_round = mix_val + (GRAY_BITS+COS_BITS+3)'(32768);
   assign gray_wide = mix_round[GRAY_BITS+COS_BITS+2:16];

   always_comb begin
      if (snap_err_ff || mix_round[GRAY_BITS+COS_BITS+2]) begin
         gray_val = '0;
      end else if (gray_wide > (GRAY_BITS+3)'(255)) begin
         gray_val = '1;
      end else begin
         gray_val = gray_wide[GRAY_BITS-1:0];
      end
   end

   // output register
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_gray_ff  <= gray_val;
         rsp_col_ff   <= snap_col_ff;
         rsp_row_ff   <= snap_row_ff;
         rsp_frame_ff <= snap_frame_ff;
         rsp_eof_ff   <= snap_eof_ff;
         rsp_eos_ff   <= snap_eos_ff;
         rsp_err_ff   <= snap_err_ff;
      end
   end

   // restoring divider, one quotient bit per step
   assign div_rem_sh = {div_rem_ff, div_work_ff[DIV_W-1]};
   assign div_ge     = div_rem_sh >= {1'b0, cfg.shift_count};

   always_comb begin
      div_work_in = div_work_ff;
      div_rem_in  = div_rem_ff;
      if (cmd.div_start) begin
         div_work_in = DIV_W'({frame_ff, {PHASE_FRAC_BITS{1'b0}}})
                     + DIV_W'(cfg.shift_count[SHIFT_CNT_BITS-1:1]);
         div_rem_in  = '0;
      end else if (cmd.div_step) begin
         div_work_in = {div_work_ff[DIV_W-2:0], div_ge};
         div_rem_in  = div_ge ? SHIFT_CNT_BITS'(div_rem_sh - {1'b0, cfg.shift_count})
                              : div_rem_sh[SHIFT_CNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      div_work_ff <= div_work_in;
      div_rem_ff  <= div_rem_in;
   end

   assign status.div_pend = div_pend_ff;
   assign status.out_free = !(rsp_valid_ff && rsp_stall);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gray         = rsp_gray_ff;
   assign rsp_column       = rsp_col_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_frame_index  = rsp_frame_ff;
   assign rsp_end_of_frame = rsp_eof_ff;
   assign rsp_end_of_set   = rsp_eos_ff;
   assign rsp_config_error = rsp_err_ff;

`ifndef SYNTHESIS
   a_eos_has_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_eos_ff || rsp_eof_ff))
      else $error("end of set without end of frame");

   a_err_no_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (!rsp_eof_ff && !rsp_eos_ff && rsp_gray_ff == '0))
      else $error("config error request carries frame marks or gray");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

   a_div_only_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (div_pend_ff && frame_ff != '0))
      else $error("divider started without a frame advance");
`endif

endmodule

/* rtl/core/sinusoidal_fringe_generator.sv */
// ---------------------------------------------------------------------------
// sinusoidal_fringe_generator
// Phase-shifted sinusoidal fringe patterns, one pixel per request, raster
// order over shift_count frames.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_restart
//   rsp      out        rsp_valid/rsp_stall  gray, column, row, frame_index,
//                                            end_of_frame, end_of_set,
//                                            config_error
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// A pixel goes through accept, phase multiply, cosine table read and mix
// into the output register. The last pixel of a frame (not of the set)
// then also runs the bit-serial frame shift divider.
// The mix step waits while the output register is full and stalled.
// Reset is synchronous; the cosine table is constant, so no fill pass.
// ---------------------------------------------------------------------------
module sinusoidal_fringe_generator
   import sfg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_restart,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [GRAY_BITS-1:0]      rsp_gray,
   output logic [DIM_BITS-1:0]       rsp_column,
   output logic [DIM_BITS-1:0]       rsp_row,
   output logic [FRAME_BITS-1:0]     rsp_frame_index,
   output logic                      rsp_end_of_frame,
   output logic                      rsp_end_of_set,
   output logic                      rsp_config_error,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type    cfg;
   logic       cfg_bad;
   logic       home;
   cmd_type    cmd;
   status_type status;

   sfg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .cfg_bad          (cfg_bad),
      .home             (home)
   );

   sfg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .cfg_bad          (cfg_bad),
      .home             (home),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_gray         (rsp_gray),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_end_of_set   (rsp_end_of_set),
      .rsp_config_error (rsp_config_error)
   );

endmodule
